>>> rtl/lbpm_pkg.sv
package lbpm_pkg;

   localparam int MAX_BARS = 32;
   localparam int IDX_W = $clog2(MAX_BARS);
   localparam int CNT_W = $clog2(MAX_BARS + 1);
   localparam int RESULT_CAP = MAX_BARS / 2;
   localparam int RES_W = $clog2(RESULT_CAP + 1);

   localparam logic [0:0] CSR_ANGLE_LIMIT = 1'd0;
   localparam logic [0:0] CSR_DIST_COEFF = 1'd1;

   typedef struct packed {
      logic [15:0] bar_x;
      logic [15:0] bar_y;
      logic signed [11:0] bar_angle;
      logic [15:0] bar_height;
      logic last_bar;
   } req_type;

   typedef struct packed {
      logic pair_valid;
      logic [15:0] pair_x;
      logic [15:0] pair_y;
      logic [4:0] left_index;
      logic [4:0] right_index;
      logic overflow;
      logic last_pair;
   } rsp_type;

   // One stored bar as it moves through the sort chain.
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic signed [11:0] angle;
      logic [15:0] height;
      logic [IDX_W-1:0] index;
   } bar_type;

endpackage

>>> rtl/lbpm_cell.sv
// One slot of the insertion-sort chain. A new bar is broadcast to all cells;
// each cell keeps its bar, takes its left neighbor's bar or the new one, so
// the row stays ordered by x with ties in arrival order.
module lbpm_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 insert,
   input  lbpm_pkg::bar_type    new_bar,
   input  logic                 left_valid,
   input  logic                 left_greater,
   input  lbpm_pkg::bar_type    left_bar,
   input  logic                 shift,
   input  lbpm_pkg::bar_type    right_bar,
   input  logic                 right_valid,
   output logic                 valid,
   output logic                 greater,
   output lbpm_pkg::bar_type    bar
);

   logic              valid_ff, valid_in;
   lbpm_pkg::bar_type bar_ff, bar_in;

   assign valid = valid_ff;
   assign bar = bar_ff;
   // Stored bar lies strictly right of the new one.
   assign greater = valid_ff && (bar_ff.x > new_bar.x);

   // Next contents: insert moves bars right of the new one up a slot;
   // shift moves the row left by a slot and empties the last one.
   always_comb begin
      valid_in = valid_ff;
      bar_in = bar_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (insert) begin
         if (greater) begin
            if (left_greater) begin
               bar_in = left_bar;
            end else begin
               bar_in = new_bar;
            end
         end else if (!valid_ff && left_valid) begin
            valid_in = 1'b1;
            bar_in = left_greater ? left_bar : new_bar;
         end else if (!valid_ff && !left_valid) begin
            // an empty slot behind another empty one stays empty
            valid_in = left_greater;
            bar_in = new_bar;
         end
      end else if (shift) begin
         valid_in = right_valid;
         bar_in = right_bar;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bar_ff <= bar_in;
   end

endmodule

>>> rtl/lbpm_chain.sv
// Row of sort cells. Cell 0 holds the smallest x.
module lbpm_chain (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              insert,
   input  lbpm_pkg::bar_type new_bar,
   input  logic              shift,
   output lbpm_pkg::bar_type bars [lbpm_pkg::MAX_BARS]
);

   logic valids [lbpm_pkg::MAX_BARS];
   logic greaters [lbpm_pkg::MAX_BARS];

   genvar g;
   generate
      for (g = 0; g < lbpm_pkg::MAX_BARS; g++) begin : g_cell
         logic              lv, lg, rv;
         lbpm_pkg::bar_type lb, rb;
         if (g == 0) begin : g_first
            // virtual left neighbor: valid, never greater
            assign lv = 1'b1;
            assign lg = 1'b0;
            assign lb = new_bar;
         end else begin : g_mid
            assign lv = valids[g-1];
            assign lg = greaters[g-1];
            assign lb = bars[g-1];
         end
         if (g == lbpm_pkg::MAX_BARS - 1) begin : g_last
            assign rv = 1'b0;
            assign rb = bars[g];
         end else begin : g_nrm
            assign rv = valids[g+1];
            assign rb = bars[g+1];
         end
         lbpm_cell u_cell (
            .clock(clock), .reset(reset), .clear(clear), .insert(insert),
            .new_bar(new_bar), .left_valid(lv), .left_greater(lg),
            .left_bar(lb), .shift(shift), .right_bar(rb), .right_valid(rv),
            .valid(valids[g]), .greater(greaters[g]), .bar(bars[g])
         );
      end
   endgenerate

endmodule

>>> rtl/light_bar_pair_matcher_unit.sv
// Light bar pair matcher.
// Bars arrive as beats on the req_ channel (valid/stall); each is placed
// into a sorted row of cells as it is taken, so loading runs one bar a cycle.
// A beat with last_bar set starts matching: the row's sorted bars are
// walked one candidate per cycle while the rsp_ channel is not stalled,
// each unpaired bar against the later unpaired bars. After the scan the
// final beat is handed out and then the row is cleared.
// The req_ channel is stalled from the last bar until the row is cleared.
// Each pair leaves as one beat on the rsp_ channel (valid/stall); a pair is
// held until the next one is found, so the last beat of the frame can carry
// last_pair. With no pair, one beat with pair_valid clear is sent. Bars
// beyond 32 in a frame are dropped and the overflow field of every result
// of that frame is set.
// A stalled rsp_ beat holds in the output register and halts the scan.
// The csr_ port writes the angle limit (index 0) and distance coefficient
// (index 1); writes are taken at any time but meant for idle periods.
// Synchronous reset empties the row, clears the flags and restores the
// register defaults (angle limit 480, coefficient 5).
module light_bar_pair_matcher_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lbpm_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lbpm_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_data
);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int N = lbpm_pkg::MAX_BARS;
   localparam int IW = lbpm_pkg::IDX_W;
   localparam int CW = lbpm_pkg::CNT_W;

   logic [1:0]  state_ff, state_in;
   logic [11:0] angle_limit_ff;
   logic [3:0]  dist_coeff_ff;
   logic [CW-1:0] count_ff, count_in;
   logic        dropped_ff, dropped_in;
   logic [N-1:0] used_ff, used_in;
   logic [IW-1:0] pos_i_ff, pos_i_in, pos_j_ff, pos_j_in;
   logic [lbpm_pkg::RES_W-1:0] res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   lbpm_pkg::rsp_type rsp_ff, rsp_in;
   logic        pend_valid_ff, pend_valid_in;
   lbpm_pkg::rsp_type pend_ff, pend_in;

   logic        accept;
   logic        insert;
   logic        out_free;
   lbpm_pkg::bar_type new_bar;
   lbpm_pkg::bar_type bars [N];

   assign accept = req_valid && !req_stall;
   assign insert = accept && (count_ff < CW'(N));
   assign req_stall = (state_ff != ST_LOAD);
   assign csr_ready = 1'b1;
   // The output register can take a new beat this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      new_bar.x = req_data.bar_x;
      new_bar.y = req_data.bar_y;
      new_bar.angle = req_data.bar_angle;
      new_bar.height = req_data.bar_height;
      new_bar.index = count_ff[IW-1:0];
   end

   lbpm_chain u_chain (
      .clock(clock), .reset(reset), .clear(state_ff == ST_DONE && !rsp_valid_ff),
      .insert(insert), .new_bar(new_bar), .shift(1'b0),
      .bars(bars)
   );

   // Candidate pair read from the sorted row at the two scan positions.
   lbpm_pkg::bar_type bar_a, bar_b;
   logic signed [12:0] angle_diff;
   logic [12:0] angle_abs;
   logic [15:0] hmax;
   logic [19:0] reach;
   logic [15:0] gap;
   logic        is_match;
   logic [16:0] sum_x, sum_y;

   assign bar_a = bars[pos_i_ff];
   assign bar_b = bars[pos_j_ff];
   always_comb begin
      angle_diff = 13'(bar_a.angle) - 13'(bar_b.angle);
      angle_abs = angle_diff[12] ? 13'(-angle_diff) : 13'(angle_diff);
      hmax = (bar_a.height > bar_b.height) ? bar_a.height : bar_b.height;
      reach = 20'(hmax) * 20'(dist_coeff_ff);
      gap = bar_b.x - bar_a.x;
      is_match = (angle_abs <= 13'(angle_limit_ff)) && (20'(gap) <= reach);
      sum_x = 17'(bar_a.x) + 17'(bar_b.x);
      sum_y = 17'(bar_a.y) + 17'(bar_b.y);
   end

   // Load, scan and clear sequencer: pos_i walks the left bar, pos_j the candidate.
   always_comb begin
      logic [CW-1:0] n_i;
      state_in = state_ff;
      count_in = count_ff;
      dropped_in = dropped_ff;
      used_in = used_ff;
      pos_i_in = pos_i_ff;
      pos_j_in = pos_j_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      n_i = CW'(pos_i_ff) + CW'(1);
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (insert) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_bar) begin
                  state_in = ST_SCAN;
                  pos_i_in = '0;
                  pos_j_in = IW'(1);
                  res_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (n_i >= count_ff || res_ff == lbpm_pkg::RES_W'(lbpm_pkg::RESULT_CAP)) begin
                  state_in = ST_DONE;
                  rsp_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     // The held pair is the final beat of the frame.
                     rsp_in = pend_ff;
                     rsp_in.last_pair = 1'b1;
                     pend_valid_in = 1'b0;
                  end else begin
                     rsp_in = '0;
                     rsp_in.overflow = dropped_ff;
                     rsp_in.last_pair = 1'b1;
                  end
               end else if (used_ff[pos_i_ff] || CW'(pos_j_ff) >= count_ff) begin
                  pos_i_in = IW'(n_i);
                  pos_j_in = IW'(n_i + CW'(1));
               end else if (!used_ff[pos_j_ff] && is_match) begin
                  used_in[pos_i_ff] = 1'b1;
                  used_in[pos_j_ff] = 1'b1;
                  // A new pair releases the one held before it.
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = pend_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_in.pair_valid = 1'b1;
                  pend_in.pair_x = sum_x[16:1];
                  pend_in.pair_y = sum_y[16:1];
                  pend_in.left_index = 5'(bar_a.index);
                  pend_in.right_index = 5'(bar_b.index);
                  pend_in.overflow = dropped_ff;
                  pend_in.last_pair = 1'b0;
                  res_in = res_ff + lbpm_pkg::RES_W'(1);
                  pos_i_in = IW'(n_i);
                  pos_j_in = IW'(n_i + CW'(1));
               end else begin
                  pos_j_in = pos_j_ff + IW'(1);
                  if (pos_j_ff == IW'(N - 1)) begin
                     pos_i_in = IW'(n_i);
                     pos_j_in = IW'(n_i + CW'(1));
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (!rsp_valid_ff) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  dropped_in = 1'b0;
                  used_in = '0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         angle_limit_ff <= 12'd480;
         dist_coeff_ff <= 4'd5;
         count_ff <= '0;
         dropped_ff <= 1'b0;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         res_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         dropped_ff <= dropped_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         res_ff <= res_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               lbpm_pkg::CSR_ANGLE_LIMIT: angle_limit_ff <= csr_data[11:0];
               lbpm_pkg::CSR_DIST_COEFF:  dist_coeff_ff <= csr_data[3:0];
               default: ;
            endcase
         end
      end
      pos_i_ff <= pos_i_in;
      pos_j_ff <= pos_j_in;
      rsp_ff <= rsp_in;
      pend_ff <= pend_in;
   end

   // Input is taken only while loading.
   a_stall_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> req_stall) else $error("input taken during scan");
   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result beat changed under stall");
   // Bar count never exceeds the row.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N)) else $error("bar count overflow");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   // One bar as the matcher keeps it for a frame.
   typedef struct {
      logic [15:0]        x;
      logic [15:0]        y;
      logic signed [11:0] angle;
      logic [15:0]        height;
   } bar_rec_type;

   // One beat of stimulus; typed rows carry a hand-written single result.
   typedef struct packed {
      lbpm_pkg::req_type item;
      logic              typed;
      lbpm_pkg::rsp_type want;
   } stim_type;

   localparam lbpm_pkg::rsp_type NO_PAIR =
      '{1'b0, 16'd0, 16'd0, 5'd0, 5'd0, 1'b0, 1'b1};
   localparam int CYCLE_LIMIT = 500000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   lbpm_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   lbpm_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [0:0]        csr_index = lbpm_pkg::CSR_ANGLE_LIMIT;
   logic [15:0]       csr_data = '0;

   light_bar_pair_matcher_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Predictor state: the frame being collected and the live register values.
   bar_rec_type frame_bars [lbpm_pkg::MAX_BARS];
   int          frame_count = 0;
   bit          frame_dropped = 0;
   logic [11:0] angle_limit = 12'd480;
   logic [3:0]  dist_coeff = 4'd5;

   stim_type          beat_q [$];
   stim_type          cur_beat;
   lbpm_pkg::rsp_type pending_pairs [$];
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   bit       sender_hold = 0;
   int       error_count = 0;
   int       cycle_count = 0;

   // Directed frames: single bar, angle extremes, a clean pair, x ties,
   // angle field extremes with reversed x order, and the gap boundary.
   stim_type directed_rows [14] = '{
      '{'{16'd0, 16'd0, 12'sd0, 16'd0, 1'b1}, 1'b1, NO_PAIR},
      '{'{16'd0, 16'd0, -12'sd1440, 16'hFFFF, 1'b0}, 1'b0, NO_PAIR},
      '{'{16'hFFFF, 16'hFFFF, 12'sd1440, 16'hFFFF, 1'b1}, 1'b1, NO_PAIR},
      '{'{16'd100, 16'hFFFF, 12'sd0, 16'hFFFF, 1'b0}, 1'b0, NO_PAIR},
      '{'{16'd200, 16'hFFFF, 12'sd0, 16'd0, 1'b1}, 1'b1,
        '{1'b1, 16'd150, 16'hFFFF, 5'd0, 5'd1, 1'b0, 1'b1}},
      '{'{16'd500, 16'd10, 12'sd0, 16'd4, 1'b0}, 1'b0, NO_PAIR},
      '{'{16'd500, 16'd20, 12'sd800, 16'd4, 1'b0}, 1'b0, NO_PAIR},
      '{'{16'd500, 16'd30, 12'sd10, 16'd4, 1'b0}, 1'b0, NO_PAIR},
      '{'{16'd500, 16'd40, 12'sd790, 16'd4, 1'b1}, 1'b0, NO_PAIR},
      '{'{16'd9000, 16'd1, 12'h800, 16'd50, 1'b0}, 1'b0, NO_PAIR},
      '{'{16'd10, 16'd2, 12'h7FF, 16'd50, 1'b1}, 1'b1, NO_PAIR},
      '{'{16'd1000, 16'd5, 12'sd3, 16'd10, 1'b0}, 1'b0, NO_PAIR},
      '{'{16'd1050, 16'd7, 12'sd3, 16'd10, 1'b0}, 1'b0, NO_PAIR},
      '{'{16'd1051, 16'd9, 12'sd3, 16'd10, 1'b1}, 1'b0, NO_PAIR}
   };

   // Store one bar; on the frame's last bar, sort by x and pair left to right.
   task automatic absorb_bar(input lbpm_pkg::req_type b,
                             output lbpm_pkg::rsp_type pairs [$]);
      int order [lbpm_pkg::MAX_BARS];
      bit used [lbpm_pkg::MAX_BARS];
      int i, j, k, v, d, hmax, gap, found;
      lbpm_pkg::rsp_type r;
      pairs = {};
      if (frame_count < lbpm_pkg::MAX_BARS) begin
         frame_bars[frame_count] = '{b.bar_x, b.bar_y, b.bar_angle, b.bar_height};
         frame_count++;
      end else begin
         frame_dropped = 1;
      end
      if (!b.last_bar) return;
      for (i = 0; i < frame_count; i++) begin
         v = i;
         k = i;
         while (k > 0 && frame_bars[order[k-1]].x > frame_bars[v].x) begin
            order[k] = order[k-1];
            k--;
         end
         order[k] = v;
         used[i] = 0;
      end
      found = 0;
      for (i = 0; i + 1 < frame_count && found < lbpm_pkg::RESULT_CAP; i++) begin
         if (used[order[i]]) continue;
         for (j = i + 1; j < frame_count; j++) begin
            if (used[order[j]]) continue;
            d = int'(frame_bars[order[i]].angle) - int'(frame_bars[order[j]].angle);
            if (d < 0) d = -d;
            hmax = frame_bars[order[i]].height > frame_bars[order[j]].height ?
                   frame_bars[order[i]].height : frame_bars[order[j]].height;
            gap = int'(frame_bars[order[j]].x) - int'(frame_bars[order[i]].x);
            if (d > int'(angle_limit) || gap > int'(dist_coeff) * hmax) continue;
            used[order[i]] = 1;
            used[order[j]] = 1;
            r.pair_valid  = 1'b1;
            r.pair_x      = 16'((17'(frame_bars[order[i]].x) + frame_bars[order[j]].x) >> 1);
            r.pair_y      = 16'((17'(frame_bars[order[i]].y) + frame_bars[order[j]].y) >> 1);
            r.left_index  = 5'(order[i]);
            r.right_index = 5'(order[j]);
            r.overflow    = frame_dropped;
            r.last_pair   = 1'b0;
            pairs = {pairs, r};
            found++;
            break;
         end
      end
      if (found == 0) begin
         r = NO_PAIR;
         r.overflow = frame_dropped;
         pairs = {pairs, r};
      end else begin
         pairs[found-1].last_pair = 1'b1;
      end
      frame_count = 0;
      frame_dropped = 0;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   // Sender: log each accepted beat with the predictor and present the next beat unless idling; a stalled beat holds.
   always @(posedge clock) begin
      lbpm_pkg::rsp_type pairs [$];
      if (!reset) begin
         if (req_valid && !req_stall) begin
            absorb_bar(cur_beat.item, pairs);
            if (cur_beat.typed) pending_pairs = {pending_pairs, cur_beat.want};
            else foreach (pairs[n]) pending_pairs = {pending_pairs, pairs[n]};
         end
         if (!req_valid || !req_stall) begin
            if (beat_q.size() > 0 && !sender_hold &&
                $urandom_range(99, 0) >= send_idle_pct) begin
               cur_beat  = beat_q.pop_front();
               req_valid <= 1'b1;
               req_data  <= cur_beat.item;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall and field-by-field check of each result beat.
   always @(posedge clock) begin
      lbpm_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pairs.size() == 0) begin
               report_mismatch("unexpected result beat", int'(rsp_data.pair_x), 0);
            end else begin
               want = pending_pairs.pop_front();
               if (rsp_data.pair_valid !== want.pair_valid)
                  report_mismatch("pair_valid", rsp_data.pair_valid, want.pair_valid);
               if (rsp_data.pair_x !== want.pair_x)
                  report_mismatch("pair_x", rsp_data.pair_x, want.pair_x);
               if (rsp_data.pair_y !== want.pair_y)
                  report_mismatch("pair_y", rsp_data.pair_y, want.pair_y);
               if (rsp_data.left_index !== want.left_index)
                  report_mismatch("left_index", rsp_data.left_index, want.left_index);
               if (rsp_data.right_index !== want.right_index)
                  report_mismatch("right_index", rsp_data.right_index, want.right_index);
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch("overflow", rsp_data.overflow, want.overflow);
               if (rsp_data.last_pair !== want.last_pair)
                  report_mismatch("last_pair", rsp_data.last_pair, want.last_pair);
            end
         end
         rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** light_bar_pair_matcher_unit: FAILED **");
         $finish;
      end
   end

   // Queue one frame: mostly clustered bars that can pair, sometimes noise,
   // and now and then more bars than the store holds.
   task automatic queue_frame(output int n);
      stim_type s;
      int base, ang0, k;
      bit clustered;
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(38, 30) : $urandom_range(10, 1);
      clustered = ($urandom_range(3, 0) != 0);
      base = $urandom_range(60000, 0);
      ang0 = $urandom_range(2880, 0) - 1440;
      for (k = 0; k < n; k++) begin
         s.typed = 1'b0;
         s.want  = NO_PAIR;
         if (clustered) begin
            s.item.bar_x      = 16'(base + $urandom_range(800, 0));
            s.item.bar_y      = 16'($urandom);
            s.item.bar_angle  = 12'(ang0 + $urandom_range(600, 0) - 300);
            s.item.bar_height = 16'($urandom_range(400, 0));
         end else begin
            s.item.bar_x      = 16'($urandom);
            s.item.bar_y      = 16'($urandom);
            s.item.bar_angle  = 12'($urandom);
            s.item.bar_height = 16'($urandom);
         end
         s.item.last_bar = (k == n - 1);
         beat_q = {beat_q, s};
      end
   endtask

   // Let every beat go out and every result come back, then settle.
   task automatic drain_all();
      while (beat_q.size() > 0 || req_valid || pending_pairs.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      if (idx == lbpm_pkg::CSR_ANGLE_LIMIT) angle_limit = value[11:0];
      else dist_coeff = value[3:0];
   endtask

   // Main sequence: reset, directed table, then six phases of random frames.
   initial begin
      int phase, sent, n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int r = 0; r < $size(directed_rows); r++) beat_q = {beat_q, directed_rows[r]};
      drain_all();
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               write_csr(lbpm_pkg::CSR_ANGLE_LIMIT, 16'h0000);
               write_csr(lbpm_pkg::CSR_DIST_COEFF, 16'h0000);
            end
            2: begin
               write_csr(lbpm_pkg::CSR_ANGLE_LIMIT, 16'hFFFF);
               write_csr(lbpm_pkg::CSR_DIST_COEFF, 16'hFFFF);
            end
            3: begin
               write_csr(lbpm_pkg::CSR_ANGLE_LIMIT, 16'($urandom));
               write_csr(lbpm_pkg::CSR_DIST_COEFF, 16'($urandom));
            end
            4: begin
               write_csr(lbpm_pkg::CSR_ANGLE_LIMIT, {4'($urandom), 12'd2880});
               write_csr(lbpm_pkg::CSR_DIST_COEFF, {12'($urandom), 4'd15});
            end
            5: begin
               write_csr(lbpm_pkg::CSR_ANGLE_LIMIT, {4'($urandom), 12'd480});
               write_csr(lbpm_pkg::CSR_DIST_COEFF, {12'($urandom), 4'd5});
            end
            default: ;
         endcase
         case (phase / 2)
            0: begin send_idle_pct = 8;  recv_idle_pct = 75; end
            1: begin send_idle_pct = 75; recv_idle_pct = 8;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         sent = 0;
         while (sent < 63) begin
            queue_frame(n);
            sent += n;
            // Hold the sender once until every pending result is back.
            if (phase == 3 && sent >= 35 && sent - n < 35) begin
               while (beat_q.size() > 0 || req_valid) @(posedge clock);
               sender_hold = 1;
               while (pending_pairs.size() > 0) @(posedge clock);
               sender_hold = 0;
            end
         end
         drain_all();
      end
      if (error_count == 0) begin
         $display("** light_bar_pair_matcher_unit: PASSED **");
      end else begin
         $display("** light_bar_pair_matcher_unit: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/lbpm_pkg.sv
rtl/lbpm_cell.sv
rtl/lbpm_chain.sv
rtl/light_bar_pair_matcher_unit.sv
bench/tb_top.sv
